// File: rtl/core/irpd_pkg.sv
// shared types and constants for the infrared pulse-distance decoder
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    localparam int unsigned IRPD_FRAME_BYTES = 5;
    localparam int unsigned IRPD_TIME_W      = 16;
    localparam int unsigned IRPD_KIND_W      = 2;
    localparam int unsigned IRPD_DATA_W      = 40;
    localparam int unsigned IRPD_CFG_IDX_W   = 3;
    localparam int unsigned IRPD_BIT_CNT_W   = 3;
    localparam int unsigned IRPD_BYTE_IDX_W  = 3;

    typedef logic [IRPD_TIME_W-1:0] t_time;

    typedef enum logic [IRPD_CFG_IDX_W-1:0] {
        CFG_LEADER_MIN = 3'd0,
        CFG_LEADER_MAX = 3'd1,
        CFG_ZERO_MIN   = 3'd2,
        CFG_ZERO_MAX   = 3'd3,
        CFG_ONE_MIN    = 3'd4,
        CFG_ONE_MAX    = 3'd5
    } t_cfg_index;

    localparam t_time RST_LEADER_MIN = 16'd8000;
    localparam t_time RST_LEADER_MAX = 16'd9500;
    localparam t_time RST_ZERO_MIN   = 16'd900;
    localparam t_time RST_ZERO_MAX   = 16'd1300;
    localparam t_time RST_ONE_MIN    = 16'd2000;
    localparam t_time RST_ONE_MAX    = 16'd2600;

    typedef struct packed {
        t_time leader_min;
        t_time leader_max;
        t_time zero_min;
        t_time zero_max;
        t_time one_min;
        t_time one_max;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEADER = 2'd1,
        PH_BITS   = 2'd2
    } t_phase;

    typedef enum logic [IRPD_KIND_W-1:0] {
        KIND_FRAME      = 2'd0,
        KIND_LEADER_ERR = 2'd1,
        KIND_BIT_ERR    = 2'd2
    } t_kind;

    typedef struct packed {
        logic                   valid;
        t_kind                  kind;
        logic [IRPD_DATA_W-1:0] data;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/irpd_cfg_regs.sv
// timing window registers with their reset values
`timescale 1ns / 1ps
`default_nettype none

module irpd_cfg_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [irpd_pkg::IRPD_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [irpd_pkg::IRPD_TIME_W-1:0]     i_cfg_data,
    output irpd_pkg::t_cfg                      o_cfg
);
    import irpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LEADER_MIN: n_cfg.leader_min = i_cfg_data;
                CFG_LEADER_MAX: n_cfg.leader_max = i_cfg_data;
                CFG_ZERO_MIN:   n_cfg.zero_min   = i_cfg_data;
                CFG_ZERO_MAX:   n_cfg.zero_max   = i_cfg_data;
                CFG_ONE_MIN:    n_cfg.one_min    = i_cfg_data;
                CFG_ONE_MAX:    n_cfg.one_max    = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min <= RST_LEADER_MIN;
            r_cfg.leader_max <= RST_LEADER_MAX;
            r_cfg.zero_min   <= RST_ZERO_MIN;
            r_cfg.zero_max   <= RST_ZERO_MAX;
            r_cfg.one_min    <= RST_ONE_MIN;
            r_cfg.one_max    <= RST_ONE_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/irpd_decode.sv
// phase machine, interval classification and byte assembly
`timescale 1ns / 1ps
`default_nettype none

module irpd_decode #(
    parameter int unsigned FRAME_BYTES = irpd_pkg::IRPD_FRAME_BYTES
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire [irpd_pkg::IRPD_TIME_W-1:0]  i_edge_interval,
    input  irpd_pkg::t_cfg                   i_cfg,
    output irpd_pkg::t_result                o_result
);
    import irpd_pkg::*;

    localparam logic [IRPD_BYTE_IDX_W:0] LastByteCount = (IRPD_BYTE_IDX_W+1)'(FRAME_BYTES);

    t_phase                     r_phase,      n_phase;
    logic [6:0]                 r_bit_shift,  n_bit_shift;
    logic [IRPD_BIT_CNT_W-1:0]  r_bit_count,  n_bit_count;
    logic [IRPD_BYTE_IDX_W-1:0] r_byte_index, n_byte_index;
    logic [IRPD_DATA_W-1:0]     r_frame,      n_frame;

    logic                       in_leader;
    logic                       in_zero;
    logic                       in_one;
    logic                       rx_bit;
    logic [7:0]                 rx_byte;
    logic [IRPD_DATA_W-1:0]     frame_next;
    logic [IRPD_BYTE_IDX_W:0]   byte_next;

    // windows are inclusive, an empty window (min above max) matches nothing
    assign in_leader = (i_edge_interval >= i_cfg.leader_min) &&
                       (i_edge_interval <= i_cfg.leader_max);
    assign in_zero   = (i_edge_interval >= i_cfg.zero_min) &&
                       (i_edge_interval <= i_cfg.zero_max);
    assign in_one    = (i_edge_interval >= i_cfg.one_min) &&
                       (i_edge_interval <= i_cfg.one_max);

    assign rx_bit     = !in_zero;
    assign rx_byte    = {r_bit_shift, rx_bit};
    assign frame_next = {r_frame[IRPD_DATA_W-9:0], rx_byte};
    assign byte_next  = {1'b0, r_byte_index} + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_bit_shift  = r_bit_shift;
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_frame      = r_frame;
        o_result     = '{valid: 1'b0, kind: KIND_FRAME, data: '0};
        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_LEADER;
                end
                PH_LEADER: begin
                    if (in_leader) begin
                        n_phase = PH_BITS;
                    end else begin
                        n_phase      = PH_IDLE;
                        n_bit_shift  = '0;
                        n_bit_count  = '0;
                        n_byte_index = '0;
                        n_frame      = '0;
                        o_result     = '{valid: 1'b1, kind: KIND_LEADER_ERR, data: '0};
                    end
                end
                PH_BITS: begin
                    if (!in_zero && !in_one) begin
                        n_phase      = PH_IDLE;
                        n_bit_shift  = '0;
                        n_bit_count  = '0;
                        n_byte_index = '0;
                        n_frame      = '0;
                        o_result     = '{valid: 1'b1, kind: KIND_BIT_ERR, data: '0};
                    end else if (r_bit_count != '1) begin
                        n_bit_shift = {r_bit_shift[5:0], rx_bit};
                        n_bit_count = r_bit_count + 1'b1;
                    end else if (byte_next >= LastByteCount) begin
                        // last byte of the frame closes it
                        n_phase      = PH_IDLE;
                        n_bit_shift  = '0;
                        n_bit_count  = '0;
                        n_byte_index = '0;
                        n_frame      = '0;
                        o_result     = '{valid: 1'b1, kind: KIND_FRAME, data: frame_next};
                    end else begin
                        n_bit_shift  = '0;
                        n_bit_count  = '0;
                        n_byte_index = byte_next[IRPD_BYTE_IDX_W-1:0];
                        n_frame      = frame_next;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_shift  <= '0;
            r_bit_count  <= '0;
            r_byte_index <= '0;
            r_frame      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_bit_shift  <= n_bit_shift;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_frame      <= n_frame;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/irpd_out_buf.sv
// result register with a skid slot for the output channel
`timescale 1ns / 1ps
`default_nettype none

module irpd_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  irpd_pkg::t_result   i_result,
    input  wire                 i_stall,
    output logic                o_full,
    output irpd_pkg::t_result   o_result
);
    import irpd_pkg::*;

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_out.valid && !i_stall;

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_out.valid || pop) begin
            // skid entry is older, it goes first
            if (r_skid.valid) begin
                n_out        = r_skid;
                n_skid.valid = 1'b0;
            end else begin
                n_out = i_result;
            end
        end else if (i_result.valid) begin
            n_skid = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out.valid  <= n_out.valid;
            r_skid.valid <= n_skid.valid;
        end
        r_out.kind  <= n_out.kind;
        r_out.data  <= n_out.data;
        r_skid.kind <= n_skid.kind;
        r_skid.data <= n_skid.data;
    end

    assign o_full   = r_skid.valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: rtl/core/ir_pulse_distance_decoder.sv
// top level of the infrared pulse-distance frame decoder
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_stall    i_edge_interval
//  out      source     o_out_valid / i_out_stall  o_result_kind, o_frame_data
//  cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// one edge request is taken per cycle while o_in_stall is low; its result,
// if any, goes to the result register, or to the skid slot while the output stalls.
// a two-entry result buffer (register plus skid slot) decouples the sides;
// input stalls only while the skid slot holds a result.
// synchronous active-low reset returns to idle with the default windows.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_decoder #(
    parameter int unsigned FRAME_BYTES = irpd_pkg::IRPD_FRAME_BYTES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [irpd_pkg::IRPD_TIME_W-1:0]     i_edge_interval,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [irpd_pkg::IRPD_KIND_W-1:0]    o_result_kind,
    output logic [irpd_pkg::IRPD_DATA_W-1:0]    o_frame_data,
    input  wire                                 i_cfg_we,
    input  wire [irpd_pkg::IRPD_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [irpd_pkg::IRPD_TIME_W-1:0]     i_cfg_data
);
    import irpd_pkg::*;

    t_cfg    cfg;
    t_result dec_result;
    t_result out_result;
    logic    buf_full;
    logic    accept;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    irpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    irpd_decode #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_edge_interval (i_edge_interval),
        .i_cfg           (cfg),
        .o_result        (dec_result)
    );

    irpd_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (dec_result),
        .i_stall  (i_out_stall),
        .o_full   (buf_full),
        .o_result (out_result)
    );

    assign o_out_valid   = out_result.valid;
    assign o_result_kind = out_result.kind;
    assign o_frame_data  = out_result.data;

endmodule

`default_nettype wire
